/* hdl/hsvrgb_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsvrgb_pkg
// Types and constants shared by the HSV to RGB converter and its channel lanes.
// ----------------------------------------------------------------------------
package hsvrgb_pkg;

    localparam int unsigned HUE_W      = 9;
    localparam int unsigned FX_W       = 9;
    localparam int unsigned K_W        = 6;
    localparam int unsigned CHAN_W     = 8;
    localparam int unsigned SCALED_W   = 14;
    localparam int unsigned RECIP_W    = 15;
    localparam int unsigned QUOT_W     = SCALED_W + RECIP_W;

    localparam int unsigned DEG_PER_SEXTANT = 60;
    localparam int unsigned HUE_WRAP        = 360;
    localparam int unsigned CHANNEL_MAX     = 255;

    // Reciprocal of 60 scaled by 2^20, rounded up; exact for inputs below 23830.
    localparam logic [RECIP_W-1:0] RECIP_60    = 15'd17477;
    localparam int unsigned        RECIP_SHIFT = 20;

    typedef enum logic [2:0] {
        SEXT_0 = 3'd0,
        SEXT_1 = 3'd1,
        SEXT_2 = 3'd2,
        SEXT_3 = 3'd3,
        SEXT_4 = 3'd4,
        SEXT_5 = 3'd5
    } t_sextant;

    typedef struct packed {
        logic     valid;
        t_sextant sextant;
    } t_ctrl;

endpackage

/* hdl/hsv_to_rgb_packer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv_to_rgb_packer
// Pipelined HSV to RGB conversion with a packed 24-bit color output.
// ----------------------------------------------------------------------------
// The converter accepts one beat on every clock cycle; busy is always low. The
// result of a beat is on the output ports, marked by o_valid, for one cycle.
// Between the edge that accepts it and the output, a beat passes the hue split
// stage, the four register stages of each channel lane and the output select
// register. The receiver cannot stall the results.
module hsv_to_rgb_packer #(
    parameter int unsigned FRACTION_BITS = 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [hsvrgb_pkg::HUE_W-1:0]   i_hue_degrees,
    input  logic [hsvrgb_pkg::FX_W-1:0]    i_saturation,
    input  logic [hsvrgb_pkg::FX_W-1:0]    i_brightness,
    output logic                           o_valid,
    output logic [hsvrgb_pkg::CHAN_W-1:0]  o_red,
    output logic [hsvrgb_pkg::CHAN_W-1:0]  o_green,
    output logic [hsvrgb_pkg::CHAN_W-1:0]  o_blue,
    output logic [23:0]                    o_packed_color
);

    localparam int unsigned ONE_FX    = 1 << FRACTION_BITS;
    localparam int unsigned LANE_DEPTH = 4;

    logic [hsvrgb_pkg::HUE_W-1:0]   n_hue;
    logic [hsvrgb_pkg::HUE_W-1:0]   n_base;
    hsvrgb_pkg::t_sextant           n_sextant;
    logic [hsvrgb_pkg::HUE_W-1:0]   n_rem_wide;
    logic [hsvrgb_pkg::FX_W-1:0]    n_sat;
    logic [hsvrgb_pkg::FX_W-1:0]    n_val;

    hsvrgb_pkg::t_ctrl              r_ctrl [LANE_DEPTH+1];
    logic [hsvrgb_pkg::FX_W-1:0]    r_sat;
    logic [hsvrgb_pkg::FX_W-1:0]    r_val;
    logic [hsvrgb_pkg::K_W-1:0]     r_rem;
    logic [hsvrgb_pkg::K_W-1:0]     n_rem_inv;

    logic [hsvrgb_pkg::CHAN_W-1:0]  cv;
    logic [hsvrgb_pkg::CHAN_W-1:0]  cp;
    logic [hsvrgb_pkg::CHAN_W-1:0]  cq;
    logic [hsvrgb_pkg::CHAN_W-1:0]  ct;

    logic [hsvrgb_pkg::CHAN_W-1:0]  n_red;
    logic [hsvrgb_pkg::CHAN_W-1:0]  n_green;
    logic [hsvrgb_pkg::CHAN_W-1:0]  n_blue;
    logic [hsvrgb_pkg::CHAN_W-1:0]  r_red;
    logic [hsvrgb_pkg::CHAN_W-1:0]  r_green;
    logic [hsvrgb_pkg::CHAN_W-1:0]  r_blue;
    logic                           r_out_valid;

    assign busy = 1'b0;

    always_comb begin
        n_hue = (32'(i_hue_degrees) >= hsvrgb_pkg::HUE_WRAP) ? '0 : i_hue_degrees;
        if (n_hue >= 9'd300) begin
            n_sextant = hsvrgb_pkg::SEXT_5;
            n_base    = 9'd300;
        end else if (n_hue >= 9'd240) begin
            n_sextant = hsvrgb_pkg::SEXT_4;
            n_base    = 9'd240;
        end else if (n_hue >= 9'd180) begin
            n_sextant = hsvrgb_pkg::SEXT_3;
            n_base    = 9'd180;
        end else if (n_hue >= 9'd120) begin
            n_sextant = hsvrgb_pkg::SEXT_2;
            n_base    = 9'd120;
        end else if (n_hue >= 9'd60) begin
            n_sextant = hsvrgb_pkg::SEXT_1;
            n_base    = 9'd60;
        end else begin
            n_sextant = hsvrgb_pkg::SEXT_0;
            n_base    = 9'd0;
        end
        n_rem_wide = n_hue - n_base;
        n_sat = (32'(i_saturation) > ONE_FX) ? hsvrgb_pkg::FX_W'(ONE_FX) : i_saturation;
        n_val = (32'(i_brightness) > ONE_FX) ? hsvrgb_pkg::FX_W'(ONE_FX) : i_brightness;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl[0] <= '0;
        end else begin
            r_ctrl[0].valid   <= start;
            r_ctrl[0].sextant <= n_sextant;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sat <= n_sat;
        r_val <= n_val;
        r_rem <= n_rem_wide[hsvrgb_pkg::K_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 1; i <= LANE_DEPTH; i++) begin
                r_ctrl[i] <= '0;
            end
        end else begin
            for (int i = 1; i <= LANE_DEPTH; i++) begin
                r_ctrl[i] <= r_ctrl[i-1];
            end
        end
    end

    assign n_rem_inv = hsvrgb_pkg::K_W'(hsvrgb_pkg::DEG_PER_SEXTANT) - r_rem;

    hsvrgb_lane #(.FRACTION_BITS(FRACTION_BITS)) u_lane_v (
        .i_clk  (i_clk),
        .i_sat  (r_sat),
        .i_val  (r_val),
        .i_k    ('0),
        .o_chan (cv)
    );

    hsvrgb_lane #(.FRACTION_BITS(FRACTION_BITS)) u_lane_p (
        .i_clk  (i_clk),
        .i_sat  (r_sat),
        .i_val  (r_val),
        .i_k    (hsvrgb_pkg::K_W'(hsvrgb_pkg::DEG_PER_SEXTANT)),
        .o_chan (cp)
    );

    hsvrgb_lane #(.FRACTION_BITS(FRACTION_BITS)) u_lane_q (
        .i_clk  (i_clk),
        .i_sat  (r_sat),
        .i_val  (r_val),
        .i_k    (r_rem),
        .o_chan (cq)
    );

    hsvrgb_lane #(.FRACTION_BITS(FRACTION_BITS)) u_lane_t (
        .i_clk  (i_clk),
        .i_sat  (r_sat),
        .i_val  (r_val),
        .i_k    (n_rem_inv),
        .o_chan (ct)
    );

    always_comb begin
        case (r_ctrl[LANE_DEPTH].sextant)
            hsvrgb_pkg::SEXT_0: begin
                n_red = cv; n_green = ct; n_blue = cp;
            end
            hsvrgb_pkg::SEXT_1: begin
                n_red = cq; n_green = cv; n_blue = cp;
            end
            hsvrgb_pkg::SEXT_2: begin
                n_red = cp; n_green = cv; n_blue = ct;
            end
            hsvrgb_pkg::SEXT_3: begin
                n_red = cp; n_green = cq; n_blue = cv;
            end
            hsvrgb_pkg::SEXT_4: begin
                n_red = ct; n_green = cp; n_blue = cv;
            end
            default: begin
                n_red = cv; n_green = cp; n_blue = cq;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= r_ctrl[LANE_DEPTH].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_red   <= n_red;
        r_green <= n_green;
        r_blue  <= n_blue;
    end

    assign o_valid        = r_out_valid;
    assign o_red          = r_red;
    assign o_green        = r_green;
    assign o_blue         = r_blue;
    assign o_packed_color = {r_red, r_green, r_blue};

    // Every accepted beat produces a result on the output ports.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |-> ##6 o_valid)
        else $error("accepted beat did not produce a result");

    // A result is only produced for an accepted beat.
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start, 6))
        else $error("result without an accepted beat");

    // Zero saturation yields a gray color.
    a_gray: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && i_saturation == '0) |-> ##6 (o_red == o_green && o_red == o_blue))
        else $error("zero saturation did not give equal channels");

    // Zero brightness yields black.
    a_black: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && i_brightness == '0) |-> ##6 (o_packed_color == 24'd0))
        else $error("zero brightness did not give black");

endmodule

/* hdl/hsvrgb_lane.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsvrgb_lane
// Four-stage channel term: floor(255 * v * (ONE*60 - s*k) / (ONE*ONE*60)).
// ----------------------------------------------------------------------------
module hsvrgb_lane #(
    parameter int unsigned FRACTION_BITS = 8
) (
    input  logic                              i_clk,
    input  logic [hsvrgb_pkg::FX_W-1:0]       i_sat,
    input  logic [hsvrgb_pkg::FX_W-1:0]       i_val,
    input  logic [hsvrgb_pkg::K_W-1:0]        i_k,
    output logic [hsvrgb_pkg::CHAN_W-1:0]     o_chan
);

    localparam int unsigned SK_W  = hsvrgb_pkg::FX_W + hsvrgb_pkg::K_W;
    localparam int unsigned A_W   = FRACTION_BITS + 6;
    localparam int unsigned MW    = (A_W > SK_W) ? A_W : SK_W;
    localparam int unsigned P_W   = A_W + hsvrgb_pkg::FX_W;
    localparam int unsigned X_W   = P_W + 8;
    localparam int unsigned XN_W  = 2 * FRACTION_BITS + hsvrgb_pkg::SCALED_W;
    localparam int unsigned XE_W  = (X_W > XN_W) ? X_W : XN_W;
    localparam logic [MW-1:0] FULL = MW'(hsvrgb_pkg::DEG_PER_SEXTANT) << FRACTION_BITS;

    logic [SK_W-1:0]                      n_sk;
    logic [MW-1:0]                        n_a_wide;
    logic [A_W-1:0]                       r_a;
    logic [hsvrgb_pkg::FX_W-1:0]          r_v1;
    logic [P_W-1:0]                       r_prod;
    logic [X_W-1:0]                       n_x;
    logic [XE_W-1:0]                      n_xe;
    logic [hsvrgb_pkg::SCALED_W-1:0]      r_y;
    logic [hsvrgb_pkg::QUOT_W-1:0]        r_q;

    assign n_sk     = SK_W'(i_sat) * SK_W'(i_k);
    assign n_a_wide = FULL - MW'(n_sk);

    always_ff @(posedge i_clk) begin
        r_a  <= n_a_wide[A_W-1:0];
        r_v1 <= i_val;
    end

    always_ff @(posedge i_clk) begin
        r_prod <= P_W'(r_v1) * P_W'(r_a);
    end

    assign n_x  = {r_prod, 8'b0} - {8'b0, r_prod};
    assign n_xe = XE_W'(n_x);

    always_ff @(posedge i_clk) begin
        r_y <= n_xe[2*FRACTION_BITS +: hsvrgb_pkg::SCALED_W];
    end

    always_ff @(posedge i_clk) begin
        r_q <= hsvrgb_pkg::QUOT_W'(r_y) * hsvrgb_pkg::QUOT_W'(hsvrgb_pkg::RECIP_60);
    end

    assign o_chan = r_q[hsvrgb_pkg::RECIP_SHIFT +: hsvrgb_pkg::CHAN_W];

endmodule

/* test/tb_hsv_to_rgb_packer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_hsv_to_rgb_packer
// Self-checking bench for the HSV to RGB converter with packed color output.
// ----------------------------------------------------------------------------
// A directed set covers every sextant, the hue wrap at 360 and above, and zero,
// full and over-range saturation and brightness. Random colors with random
// start gaps follow. A scoreboard predicts each accepted beat with exact integer
// arithmetic and checks every strobed result in order.
module tb_hsv_to_rgb_packer;

    localparam int unsigned FRACTION_BITS   = 8;
    localparam int unsigned RANDOM_BEATS    = 2000;
    localparam int unsigned STALL_LIMIT     = 500;
    localparam int unsigned DRAIN_CYCLES    = 12;
    localparam int unsigned HUE_W           = hsvrgb_pkg::HUE_W;
    localparam int unsigned FX_W            = hsvrgb_pkg::FX_W;
    localparam int unsigned CHAN_W          = hsvrgb_pkg::CHAN_W;
    localparam int unsigned DEG_PER_SEXTANT = hsvrgb_pkg::DEG_PER_SEXTANT;
    localparam int unsigned HUE_WRAP        = hsvrgb_pkg::HUE_WRAP;
    localparam int unsigned CHANNEL_MAX     = hsvrgb_pkg::CHANNEL_MAX;

    typedef struct {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic [23:0]       packed_color;
    } t_rgb;

    class hsv_color_scoreboard;
        t_rgb        expected_colors[$];
        int unsigned errors;

        function new();
            errors = 0;
        endfunction

        function logic [CHAN_W-1:0] scale_channel(longint unsigned s,
                                                  longint unsigned v,
                                                  longint unsigned k);
            longint unsigned one;
            longint unsigned num;
            longint unsigned den;
            one = longint'(1) << FRACTION_BITS;
            num = CHANNEL_MAX * v * (one * DEG_PER_SEXTANT - s * k);
            den = one * one * DEG_PER_SEXTANT;
            return CHAN_W'(num / den);
        endfunction

        function void note_hsv(logic [HUE_W-1:0] hue, logic [FX_W-1:0] sat,
                               logic [FX_W-1:0] val);
            longint unsigned      one;
            longint unsigned      h;
            longint unsigned      s;
            longint unsigned      v;
            longint unsigned      rem;
            hsvrgb_pkg::t_sextant sext;
            logic [CHAN_W-1:0]    cv, cp, cq, ct;
            t_rgb                 c;
            one = longint'(1) << FRACTION_BITS;
            h = (hue >= HUE_WRAP) ? 0 : hue;
            s = (sat > one) ? one : sat;
            v = (val > one) ? one : val;
            sext = hsvrgb_pkg::t_sextant'(h / DEG_PER_SEXTANT);
            rem = h % DEG_PER_SEXTANT;
            cv = scale_channel(s, v, 0);
            cp = scale_channel(s, v, DEG_PER_SEXTANT);
            cq = scale_channel(s, v, rem);
            ct = scale_channel(s, v, DEG_PER_SEXTANT - rem);
            case (sext)
                hsvrgb_pkg::SEXT_0: begin c.red = cv; c.green = ct; c.blue = cp; end
                hsvrgb_pkg::SEXT_1: begin c.red = cq; c.green = cv; c.blue = cp; end
                hsvrgb_pkg::SEXT_2: begin c.red = cp; c.green = cv; c.blue = ct; end
                hsvrgb_pkg::SEXT_3: begin c.red = cp; c.green = cq; c.blue = cv; end
                hsvrgb_pkg::SEXT_4: begin c.red = ct; c.green = cp; c.blue = cv; end
                default: begin c.red = cv; c.green = cp; c.blue = cq; end
            endcase
            c.packed_color = {c.red, c.green, c.blue};
            expected_colors.push_back(c);
        endfunction

        function void check_rgb(logic [CHAN_W-1:0] red, logic [CHAN_W-1:0] green,
                                logic [CHAN_W-1:0] blue, logic [23:0] packed_color);
            t_rgb c;
            if (expected_colors.size() == 0) begin
                $display("%0t: unexpected result beat %h", $time, packed_color);
                errors++;
                return;
            end
            c = expected_colors.pop_front();
            if (red !== c.red) begin
                $display("%0t: red expected %0d actual %0d", $time, c.red, red);
                errors++;
            end
            if (green !== c.green) begin
                $display("%0t: green expected %0d actual %0d", $time, c.green, green);
                errors++;
            end
            if (blue !== c.blue) begin
                $display("%0t: blue expected %0d actual %0d", $time, c.blue, blue);
                errors++;
            end
            if (packed_color !== c.packed_color) begin
                $display("%0t: packed color expected %h actual %h", $time,
                         c.packed_color, packed_color);
                errors++;
            end
        endfunction
    endclass

    logic                i_clk;
    logic                i_rst_n;
    logic                start;
    logic                busy;
    logic [HUE_W-1:0]    i_hue_degrees;
    logic [FX_W-1:0]     i_saturation;
    logic [FX_W-1:0]     i_brightness;
    logic                o_valid;
    logic [CHAN_W-1:0]   o_red;
    logic [CHAN_W-1:0]   o_green;
    logic [CHAN_W-1:0]   o_blue;
    logic [23:0]         o_packed_color;

    hsv_color_scoreboard sb;
    int unsigned         stall_cycles;
    bit                  no_idle;

    hsv_to_rgb_packer #(
        .FRACTION_BITS(FRACTION_BITS)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_hue_degrees (i_hue_degrees),
        .i_saturation  (i_saturation),
        .i_brightness  (i_brightness),
        .o_valid       (o_valid),
        .o_red         (o_red),
        .o_green       (o_green),
        .o_blue        (o_blue),
        .o_packed_color(o_packed_color)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy) begin
                sb.note_hsv(i_hue_degrees, i_saturation, i_brightness);
            end
            if (o_valid) begin
                sb.check_rgb(o_red, o_green, o_blue, o_packed_color);
            end
            if ((start && !busy) || o_valid) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
                if (stall_cycles >= STALL_LIMIT) begin
                    $display("%0t: no beat accepted for %0d cycles", $time, STALL_LIMIT);
                    $display("tb_hsv_to_rgb_packer NOT OK");
                    $finish;
                end
            end
        end
    end

    function automatic logic [FX_W-1:0] pick_fraction();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 8) return FX_W'(1 << FRACTION_BITS);
        if (r < 12) return '0;
        if (r < 20) return FX_W'($urandom_range((1 << FRACTION_BITS) + 1, 511));
        return FX_W'($urandom_range(0, 1 << FRACTION_BITS));
    endfunction

    function automatic logic [HUE_W-1:0] pick_hue();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 10) return HUE_W'($urandom_range(HUE_WRAP, 511));
        if (r < 18) return HUE_W'($urandom_range(0, 5) * DEG_PER_SEXTANT
                                  + $urandom_range(0, 1) * (DEG_PER_SEXTANT - 1));
        return HUE_W'($urandom_range(0, HUE_WRAP - 1));
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        if (no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic send_beat(input logic [HUE_W-1:0] hue, input logic [FX_W-1:0] sat,
                             input logic [FX_W-1:0] val);
        @(negedge i_clk);
        start         = 1'b1;
        i_hue_degrees = hue;
        i_saturation  = sat;
        i_brightness  = val;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic idle_for(input int unsigned cycles);
        repeat (cycles) begin
            @(negedge i_clk);
            start         = 1'b0;
            i_hue_degrees = HUE_W'($urandom);
            i_saturation  = FX_W'($urandom);
            i_brightness  = FX_W'($urandom);
        end
    endtask

    initial begin
        logic [HUE_W-1:0] dir_hue[22];
        logic [FX_W-1:0]  dir_sat[22];
        logic [FX_W-1:0]  dir_val[22];
        int unsigned      sent;
        int unsigned      run_len;

        sb            = new();
        stall_cycles  = 0;
        no_idle       = 1'b0;
        start         = 1'b0;
        i_hue_degrees = '0;
        i_saturation  = '0;
        i_brightness  = '0;
        i_rst_n       = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        dir_hue = '{0, 59, 60, 119, 120, 179, 180, 239, 240, 299, 300, 359,
                    360, 511, 30, 90, 150, 210, 270, 330, 1, 256};
        dir_sat = '{256, 256, 256, 256, 256, 256, 256, 256, 256, 256, 256, 256,
                    256, 256, 0, 511, 257, 128, 1, 255, 200, 100};
        dir_val = '{256, 256, 256, 256, 256, 256, 256, 256, 256, 256, 256, 256,
                    200, 200, 256, 511, 0, 1, 257, 255, 128, 100};
        no_idle = 1'b1;
        foreach (dir_hue[i]) send_beat(dir_hue[i], dir_sat[i], dir_val[i]);
        no_idle = 1'b0;
        send_beat(9'd511, 9'd511, 9'd511);
        idle_for(3);
        send_beat(9'd0, 9'd0, 9'd0);

        sent = 0;
        while (sent < RANDOM_BEATS) begin
            run_len = $urandom_range(20, 100);
            no_idle = ($urandom_range(0, 3) == 0);
            repeat (run_len) begin
                send_beat(pick_hue(), pick_fraction(), pick_fraction());
                idle_for(pick_gap());
                sent++;
            end
        end
        idle_for(1);

        while (sb.expected_colors.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0 && sb.expected_colors.size() == 0) begin
            $display("tb_hsv_to_rgb_packer OK");
        end else begin
            $display("tb_hsv_to_rgb_packer NOT OK");
        end
        $finish;
    end
endmodule
